### rtl/qsrd_pkg.sv
package qsrd_pkg;

  localparam int CodeWidth   = 8;
  localparam int SymbolWidth = 7;
  localparam int RepeatWidth = 8;
  localparam int OutDataWidth = 16;

  localparam logic [CodeWidth-1:0]   LineEndCode = 8'd32;
  localparam logic [CodeWidth-1:0]   TermCode    = 8'd0;
  localparam logic [SymbolWidth-1:0] NewlineCode = 7'd10;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_PEND = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  typedef struct packed {
    logic                   line_end;
    logic [RepeatWidth-1:0] repeat_res;
    logic [SymbolWidth-1:0] symbol;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

### rtl/qsrd_decode.sv
module qsrd_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [qsrd_pkg::CodeWidth-1:0] in_code,
  input  logic                      room,
  output qsrd_pkg::push_t           push
);
  import qsrd_pkg::*;

  logic                   byte_valid;
  logic [CodeWidth-1:0]   code;
  logic [1:0]             mode;
  logic [1:0]             mode_next;
  logic [SymbolWidth-1:0] cur_sym;
  logic [SymbolWidth-1:0] cur_sym_next;
  logic [SymbolWidth-1:0] prev_sym;
  logic [SymbolWidth-1:0] prev_sym_next;
  logic                   last_sym;
  logic                   last_sym_next;
  logic                   take;
  logic                   is_sym;
  logic                   is_cnt;
  logic [RepeatWidth-1:0] reps;
  push_t                  res;

  assign in_ready = !byte_valid || room;
  assign take     = byte_valid && room;

  assign is_sym = !code[7] && (code > LineEndCode);
  assign is_cnt = code[7] || ((code != TermCode) && (code < LineEndCode));
  assign reps   = code[7] ? (~code + 8'd1) : code;

  always_comb begin
    res           = '0;
    mode_next     = mode;
    cur_sym_next  = cur_sym;
    prev_sym_next = prev_sym;
    last_sym_next = last_sym;
    if (mode != MODE_PEND && mode != MODE_RUN) begin
      if (is_sym) begin
        cur_sym_next = code[SymbolWidth-1:0];
        mode_next    = MODE_PEND;
      end
    end else if (is_sym) begin
      if (mode == MODE_PEND) begin
        res.count     = 2'd1;
        res.first     = '{line_end: 1'b0, repeat_res: 8'd1, symbol: cur_sym};
        prev_sym_next = cur_sym;
        last_sym_next = 1'b1;
      end
      cur_sym_next = code[SymbolWidth-1:0];
      mode_next    = MODE_PEND;
    end else if (is_cnt) begin
      res.count     = 2'd1;
      res.first     = '{line_end: 1'b0, repeat_res: reps, symbol: cur_sym};
      cur_sym_next  = prev_sym;
      prev_sym_next = cur_sym;
      last_sym_next = 1'b0;
      mode_next     = MODE_RUN;
    end else begin
      if (code == LineEndCode) begin
        if (mode == MODE_PEND) begin
          res.count  = 2'd2;
          res.first  = '{line_end: 1'b0, repeat_res: 8'd1, symbol: cur_sym};
          res.second = '{line_end: 1'b1, repeat_res: 8'd1, symbol: NewlineCode};
        end else begin
          res.count = 2'd1;
          res.first = '{line_end: 1'b1, repeat_res: 8'd1, symbol: NewlineCode};
        end
      end else begin
        res.count = 2'd1;
        if (mode == MODE_PEND && last_sym) begin
          res.first = '{line_end: 1'b1, repeat_res: 8'd1, symbol: cur_sym};
        end else begin
          res.first = '{line_end: 1'b1, repeat_res: 8'd0, symbol: 7'd0};
        end
      end
      mode_next     = MODE_IDLE;
      cur_sym_next  = '0;
      prev_sym_next = '0;
      last_sym_next = 1'b1;
    end
  end

  always_comb begin
    push = res;
    if (!take) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      mode       <= MODE_IDLE;
      cur_sym    <= '0;
      prev_sym   <= '0;
      last_sym   <= 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        byte_valid <= 1'b1;
      end else if (take) begin
        byte_valid <= 1'b0;
      end
      if (take) begin
        mode     <= mode_next;
        cur_sym  <= cur_sym_next;
        prev_sym <= prev_sym_next;
        last_sym <= last_sym_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code <= in_code;
    end
  end

endmodule

### rtl/qsrd_fifo.sv
module qsrd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  qsrd_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output qsrd_pkg::res_t  out_res
);
  import qsrd_pkg::*;

  res_t       mem [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] count;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= 3'd2;
  assign out_res   = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 2'd1;
      end
      tail  <= tail + push.count;
      count <= count + {1'b0, push.count} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[tail + 2'd1] <= push.second;
    end
  end

endmodule

### rtl/quality_score_run_decoder.sv
// An input byte is registered in the decoder, and its results are registered in the result queue.
// One code byte is accepted every cycle; a byte yields zero, one or two results,
// and the four-entry result queue holds the input when fewer than two entries are free.
// Output gives one result per cycle while m_axis_tready is high; a line end after a pending symbol gives two.
// Synchronous active-high reset empties the queue and returns the decoder to its line-start state.
module quality_score_run_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [qsrd_pkg::CodeWidth-1:0]      s_axis_tdata,  // [7:0] code_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [qsrd_pkg::OutDataWidth-1:0]   m_axis_tdata,  // [6:0] symbol, [14:7] repeat_res
  output logic                                m_axis_tlast   // line_end
);
  import qsrd_pkg::*;

  push_t push;
  res_t  out_res;
  logic  room;

  qsrd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_code  (s_axis_tdata),
    .room     (room),
    .push     (push)
  );

  qsrd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.repeat_res, out_res.symbol};
  assign m_axis_tlast = out_res.line_end;

endmodule
